@@ hdl/tsog_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, register codes and constants for the three-sigma outlier gate.
package tsog_pkg;

    localparam int ANGLE_W              = 24;
    localparam int FLOOR_W              = 20;
    localparam int KSQ_W                = 7;
    localparam int LIMIT_W              = 4;
    localparam int FILL_OUT_W           = 4;
    localparam int CFG_IDX_W            = 2;
    localparam int CFG_DATA_W           = FLOOR_W;
    localparam int DEFAULT_WINDOW_DEPTH = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_MULT_SQ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_RUN_LIMIT  = 2'd2;

    // Configuration reset values
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 20'd10486;
    localparam logic [KSQ_W-1:0]   KSQ_RESET   = 7'd9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic signed [ANGLE_W-1:0] angle;
    } sample_t;

    typedef struct packed {
        logic                  accepted;
        logic                  window_cleared;
        logic [FILL_OUT_W-1:0] fill_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STAT,
        ST_DEV,
        ST_SCALE,
        ST_UPDATE
    } state_t;

endpackage

@@ hdl/three_sigma_outlier_gate.sv @@
`timescale 1ns / 1ps
// Three-sigma outlier gate over a sliding window of accepted angle samples.
//
// Each sample beat is checked against mean +/- k*sigma of the last WINDOW_DEPTH
// accepted samples (variance floored at variance_floor), using the exact test
// (n*x - sum)^2 > k^2 * max(n*sumsq - sum^2, n^2*floor) with no divide or root.
// Until the window is full, every sample is stored and accepted. One item is in
// work at a time. A clear command goes from ST_IDLE straight to ST_UPDATE, a
// sample while the window fills through ST_STAT, and one on a full window through
// ST_STAT, ST_DEV and ST_SCALE; the result is registered as ST_UPDATE commits.
// On a full window one shared signed multiplier forms sum^2, the deviation square
// and the sum-of-squares delta (x-old)*(x+old) in ST_STAT, ST_DEV and ST_SCALE
// in turn, the last one together with the k^2 scaling, and the compare and
// write-back follow in ST_UPDATE. The next beat is taken in ST_IDLE, after the
// result is registered. A result that waits on result_ready holds the write-back
// of the following item. The oldest window entry is read from the window memory
// on the accept edge. A new beat is taken while a finished result waits in the
// output register. No clearing pass is needed.
module three_sigma_outlier_gate #(
    parameter int WINDOW_DEPTH = tsog_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  tsog_pkg::sample_t               sample,
    output logic                            result_valid,
    input  logic                            result_ready,
    output tsog_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [tsog_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsog_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ANGLE_W = tsog_pkg::ANGLE_W;
    localparam int LIMIT_W = tsog_pkg::LIMIT_W;
    localparam int KSQ_W   = tsog_pkg::KSQ_W;
    localparam int FLOOR_W = tsog_pkg::FLOOR_W;
    localparam int LOG_D   = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int PTR_W   = LOG_D;
    localparam int SUM_W   = ANGLE_W + LOG_D;
    localparam int SQ_W    = 2 * ANGLE_W - 1 + LOG_D;
    localparam int DEV_W   = SUM_W + 1;
    localparam int PROD_W  = 2 * DEV_W;
    localparam int SPR_W   = PROD_W + 1;
    localparam int BASE_W  = SQ_W + LOG_D;
    localparam int THR_W   = BASE_W + KSQ_W;
    localparam int CMP_W   = (THR_W > PROD_W - 1) ? THR_W : PROD_W - 1;

    localparam logic signed [DEV_W-1:0] N_DEV   = DEV_W'(WINDOW_DEPTH);
    localparam logic signed [SPR_W-1:0] N_SPR   = SPR_W'(WINDOW_DEPTH);
    localparam logic [BASE_W-1:0]       N2_BASE = BASE_W'(WINDOW_DEPTH * WINDOW_DEPTH);
    localparam logic [CNT_W-1:0]        FULL_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [PTR_W-1:0]        LAST_PTR = PTR_W'(WINDOW_DEPTH - 1);

    // Sequencer
    tsog_pkg::state_t state_reg, state_next;
    logic             commit;

    // Captured beat and oldest entry
    logic                      cmd_reg;
    logic signed [ANGLE_W-1:0] x_reg;
    logic signed [ANGLE_W-1:0] old_reg;

    // Window memory and running statistics
    logic signed [ANGLE_W-1:0] window_mem [WINDOW_DEPTH];
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [PTR_W-1:0]          ptr_reg, ptr_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]           sumsq_reg, sumsq_next;
    logic [LIMIT_W-1:0]        run_reg, run_next;
    logic [LIMIT_W:0]          run_inc;

    // Configuration
    logic [FLOOR_W-1:0] floor_reg;
    logic [KSQ_W-1:0]   ksq_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Datapath
    logic                      full;
    logic signed [DEV_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DEV_W-1:0]   d_reg;
    logic signed [SPR_W-1:0]   spread;
    logic [BASE_W-1:0]         spread_pos, floor_n2, base_next, base_reg;
    logic [PROD_W-2:0]         lhs_reg;
    logic [THR_W-1:0]          thr_reg;
    logic                      outlier;

    // Write-back controls
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               accepted, cleared;
    tsog_pkg::result_t  result_reg;
    logic               result_valid_reg;

    assign full    = (fill_reg == FULL_CNT);
    assign run_inc = {1'b0, run_reg} + (LIMIT_W + 1)'(1);
    assign outlier = CMP_W'(lhs_reg) > CMP_W'(thr_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsog_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = (sample.cmd == tsog_pkg::CMD_CLEAR) ?
                                 tsog_pkg::ST_UPDATE : tsog_pkg::ST_STAT;
                end
            end
            tsog_pkg::ST_STAT:   state_next = full ? tsog_pkg::ST_DEV : tsog_pkg::ST_UPDATE;
            tsog_pkg::ST_DEV:    state_next = tsog_pkg::ST_SCALE;
            tsog_pkg::ST_SCALE:  state_next = tsog_pkg::ST_UPDATE;
            tsog_pkg::ST_UPDATE: state_next = commit ? tsog_pkg::ST_IDLE : tsog_pkg::ST_UPDATE;
            default:             state_next = tsog_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operand select
    always_comb
    begin
        sample_ready = (state_reg == tsog_pkg::ST_IDLE);
        commit       = (state_reg == tsog_pkg::ST_UPDATE) &&
                       (!result_valid_reg || result_ready);
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            tsog_pkg::ST_STAT:
            begin
                // sum^2 for the spread, or x^2 while the window fills
                mul_a = full ? DEV_W'(sum_reg) : DEV_W'(x_reg);
                mul_b = mul_a;
            end
            tsog_pkg::ST_DEV:
            begin
                mul_a = d_reg;
                mul_b = d_reg;
            end
            tsog_pkg::ST_SCALE:
            begin
                // x^2 - old^2 as one product
                mul_a = DEV_W'(x_reg) - DEV_W'(old_reg);
                mul_b = DEV_W'(x_reg) + DEV_W'(old_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsog_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the beat and read the oldest entry on accept
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            cmd_reg <= sample.cmd;
            x_reg   <= sample.angle;
            old_reg <= window_mem[ptr_reg];
        end
    end

    // Write back the window; writes land only in ST_UPDATE, reads only on accept,
    // so the two never touch the same entry in one cycle
    always_ff @(posedge clk)
    begin
        if (commit && wr_en)
        begin
            window_mem[wr_addr] <= x_reg;
        end
    end

    // Spread and floored base of the band
    always_comb
    begin
        spread     = $signed(SPR_W'(sumsq_reg)) * N_SPR - SPR_W'(prod_reg);
        spread_pos = spread[SPR_W-1] ? '0 : spread[BASE_W-1:0];
        floor_n2   = BASE_W'(floor_reg) * N2_BASE;
        base_next  = (spread_pos > floor_n2) ? spread_pos : floor_n2;
    end

    // Shared multiplier and test registers
    always_ff @(posedge clk)
    begin
        if (state_reg != tsog_pkg::ST_IDLE && state_reg != tsog_pkg::ST_UPDATE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == tsog_pkg::ST_STAT)
        begin
            d_reg <= N_DEV * DEV_W'(x_reg) - DEV_W'(sum_reg);
        end
        if (state_reg == tsog_pkg::ST_DEV)
        begin
            base_reg <= base_next;
        end
        if (state_reg == tsog_pkg::ST_SCALE)
        begin
            thr_reg <= THR_W'(base_reg) * THR_W'(ksq_reg);
            lhs_reg <= prod_reg[PROD_W-2:0];
        end
    end

    // Decide and form the state update
    always_comb
    begin
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        run_next   = run_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        accepted   = 1'b1;
        cleared    = 1'b0;
        priority if (cmd_reg == tsog_pkg::CMD_CLEAR)
        begin
            fill_next  = '0;
            ptr_next   = '0;
            sum_next   = '0;
            sumsq_next = '0;
            run_next   = '0;
        end
        else if (!full)
        begin
            // Fill: store at the fill position, prod_reg holds x^2
            wr_en      = 1'b1;
            wr_addr    = fill_reg[PTR_W-1:0];
            fill_next  = fill_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(x_reg);
            sumsq_next = sumsq_reg + prod_reg[SQ_W-1:0];
            run_next   = '0;
        end
        else if (outlier)
        begin
            accepted = 1'b0;
            if (run_inc > {1'b0, limit_reg})
            begin
                // Drop the whole window after too long a reject run
                cleared    = 1'b1;
                fill_next  = '0;
                ptr_next   = '0;
                sum_next   = '0;
                sumsq_next = '0;
                run_next   = '0;
            end
            else
            begin
                run_next = run_inc[LIMIT_W-1:0];
            end
        end
        else
        begin
            // Replace the oldest entry, prod_reg holds x^2 - old^2
            wr_en      = 1'b1;
            wr_addr    = ptr_reg;
            ptr_next   = (ptr_reg == LAST_PTR) ? '0 : ptr_reg + PTR_W'(1);
            sum_next   = sum_reg + SUM_W'(x_reg) - SUM_W'(old_reg);
            sumsq_next = sumsq_reg + prod_reg[SQ_W-1:0];
            run_next   = '0;
        end
    end

    // Commit statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            ptr_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            run_reg   <= '0;
        end
        else if (commit)
        begin
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            run_reg   <= run_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            result_reg.accepted       <= accepted;
            result_reg.window_cleared <= cleared;
            result_reg.fill_count     <= tsog_pkg::FILL_OUT_W'(fill_next);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= tsog_pkg::FLOOR_RESET;
            ksq_reg   <= tsog_pkg::KSQ_RESET;
            limit_reg <= tsog_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsog_pkg::CFG_VARIANCE_FLOOR: floor_reg <= cfg_data[FLOOR_W-1:0];
                tsog_pkg::CFG_SIGMA_MULT_SQ:  ksq_reg   <= cfg_data[KSQ_W-1:0];
                tsog_pkg::CFG_BAD_RUN_LIMIT:  limit_reg <= cfg_data[LIMIT_W-1:0];
                default:                      ;
            endcase
        end
    end

endmodule

@@ hdl/tsog_check.sv @@
`timescale 1ns / 1ps
// Port-level checker for the three-sigma outlier gate, with its bind.
module tsog_check #(
    parameter int WINDOW_DEPTH = tsog_pkg::DEFAULT_WINDOW_DEPTH
) (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_ready,
    input logic              result_valid,
    input logic              result_ready,
    input tsog_pkg::result_t result
);

    localparam logic [tsog_pkg::FILL_OUT_W-1:0] FULL_OUT =
        tsog_pkg::FILL_OUT_W'(WINDOW_DEPTH);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

    // One item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while an item is in work");

    // A window clear comes only with a rejection and leaves the window empty
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.window_cleared |->
            !result.accepted && (result.fill_count == '0))
    else $error("window clear with bad accept flag or fill count");

    // A plain rejection happens only on a full window
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.accepted && !result.window_cleared |->
            result.fill_count == FULL_OUT)
    else $error("rejection reported on a window that is not full");

endmodule

bind three_sigma_outlier_gate tsog_check #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_tsog_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

@@ tb/tsog_checker.sv @@
`timescale 1ns / 1ps
// Checker for the outlier gate: predicts each gate decision and compares result beats.
module tsog_checker
    import tsog_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  sample_ready,
    input  sample_t               sample,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_decisions,
    output int                    decisions_checked,
    output int                    samples_rejected,
    output int                    window_wipes
);

    // Shadow copy of the gate registers
    logic [FLOOR_W-1:0] floor_reg;
    logic [KSQ_W-1:0]   ksq_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Shadow copy of the sliding window and its running statistics
    logic signed [ANGLE_W-1:0] win_mem [WINDOW_DEPTH];
    int unsigned               fill_lvl;
    int unsigned               oldest_idx;
    int unsigned               reject_cnt;
    longint                    win_sum;
    longint                    win_sumsq;

    result_t expected_decisions [$];

    function automatic void empty_window();
        fill_lvl   = 0;
        oldest_idx = 0;
        reject_cnt = 0;
        win_sum    = 0;
        win_sumsq  = 0;
    endfunction

    // Exact 3-sigma test: (n*x - sum)^2 > k^2 * max(n*sumsq - sum^2, n^2*floor)
    function automatic bit beyond_band(longint x);
        longint       n;
        longint       dev;
        longint       spread;
        longint       floor_term;
        longint       base;
        logic [127:0] dev_sq;
        logic [127:0] band;
        n          = WINDOW_DEPTH;
        dev        = n * x - win_sum;
        if (dev < 0)
            dev = -dev;
        dev_sq     = {64'd0, dev} * {64'd0, dev};
        spread     = n * win_sumsq - win_sum * win_sum;
        floor_term = n * n * longint'(floor_reg);
        base       = (spread > floor_term) ? spread : floor_term;
        band       = {64'd0, base} * {121'd0, ksq_reg};
        return dev_sq > band;
    endfunction

    // Advance the shadow window by one input beat and form the decision it causes
    function automatic result_t predict_decision(sample_t s);
        result_t     r;
        longint      x;
        longint      old;
        int unsigned p;
        r.accepted       = 1'b1;
        r.window_cleared = 1'b0;
        if (s.cmd == CMD_CLEAR)
            empty_window();
        else
        begin
            x = longint'($signed(s.angle));
            if (fill_lvl < WINDOW_DEPTH)
            begin
                win_mem[fill_lvl] = s.angle;
                fill_lvl++;
                win_sum    += x;
                win_sumsq  += x * x;
                reject_cnt = 0;
            end
            else if (beyond_band(x))
            begin
                r.accepted = 1'b0;
                if (reject_cnt + 1 > limit_reg)
                begin
                    empty_window();
                    r.window_cleared = 1'b1;
                end
                else
                    reject_cnt++;
            end
            else
            begin
                // displace the oldest entry
                p          = oldest_idx % WINDOW_DEPTH;
                old        = longint'(win_mem[p]);
                win_sum    += x - old;
                win_sumsq  += x * x - old * old;
                win_mem[p] = s.angle;
                oldest_idx = (p + 1) % WINDOW_DEPTH;
                reject_cnt = 0;
            end
        end
        r.fill_count = FILL_OUT_W'(fill_lvl);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t oldest;
        result_t fresh;
        if (!rst_n)
        begin
            floor_reg = FLOOR_RESET;
            ksq_reg   = KSQ_RESET;
            limit_reg = LIMIT_RESET;
            foreach (win_mem[i])
                win_mem[i] = '0;
            empty_window();
            expected_decisions.delete();
            fail_count        = 0;
            decisions_checked = 0;
            samples_rejected  = 0;
            window_wipes      = 0;
            pending_decisions <= 0;
        end
        else
        begin
            // track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VARIANCE_FLOOR: floor_reg = cfg_data[FLOOR_W-1:0];
                    CFG_SIGMA_MULT_SQ:  ksq_reg   = cfg_data[KSQ_W-1:0];
                    CFG_BAD_RUN_LIMIT:  limit_reg = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            // compare a result beat with the oldest decision waiting
            if (result_valid && result_ready)
            begin
                if (expected_decisions.size() == 0)
                begin
                    $error("result beat with no decision pending");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_decisions.pop_front();
                    decisions_checked++;
                    if (result.accepted !== oldest.accepted)
                    begin
                        $error("accepted: expected %0d, actual %0d",
                               oldest.accepted, result.accepted);
                        fail_count++;
                    end
                    if (result.window_cleared !== oldest.window_cleared)
                    begin
                        $error("window_cleared: expected %0d, actual %0d",
                               oldest.window_cleared, result.window_cleared);
                        fail_count++;
                    end
                    if (result.fill_count !== oldest.fill_count)
                    begin
                        $error("fill_count: expected %0d, actual %0d",
                               oldest.fill_count, result.fill_count);
                        fail_count++;
                    end
                end
            end

            // predict the decision for an accepted input beat
            if (sample_valid && sample_ready)
            begin
                fresh = predict_decision(sample);
                if (!fresh.accepted)
                    samples_rejected++;
                if (fresh.window_cleared)
                    window_wipes++;
                expected_decisions = {expected_decisions, fresh};
            end

            pending_decisions <= expected_decisions.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the outlier gate: clock, reset, stimulus, handshake pacing and verdict.
module tb_top;
    import tsog_pkg::*;

    localparam int RX_LONG_HOLD = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 116;
    localparam int ANGLE_MAX    = (1 << (ANGLE_W - 1)) - 1;
    localparam int ANGLE_MIN    = -(1 << (ANGLE_W - 1));

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    sample_t               sample       = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_VARIANCE_FLOOR;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // receiver and sender pacing, written by the stimulus process
    bit rx_stall_en = 1'b0;
    int rx_hold_req = 0;
    bit tx_gaps_en  = 1'b0;

    int fail_count;
    int pending_decisions;
    int decisions_checked;
    int samples_rejected;
    int window_wipes;
    int beats_sent   = 0;
    int clear_cmds   = 0;
    int settings_run = 0;

    // current cluster of well-formed angles
    int center       = 0;
    int spread       = 0;
    int outlier_left = 0;

    always #1 clk = ~clk;

    three_sigma_outlier_gate u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tsog_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .sample            (sample),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .result            (result),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .pending_decisions (pending_decisions),
        .decisions_checked (decisions_checked),
        .samples_rejected  (samples_rejected),
        .window_wipes      (window_wipes)
    );

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side: short random stalls, plus one long hold on request
    initial
    begin : receiver
        int holds_done;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req != holds_done)
            begin
                holds_done = rx_hold_req;
                result_ready <= 1'b0;
                repeat (RX_LONG_HOLD) @(posedge clk);
                result_ready <= 1'b1;
            end
            else if (rx_stall_en && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    function automatic sample_t beat(logic cmd, int a);
        sample_t s;
        if (a > ANGLE_MAX)
            a = ANGLE_MAX;
        if (a < ANGLE_MIN)
            a = ANGLE_MIN;
        s.cmd   = cmd;
        s.angle = ANGLE_W'(a);
        return s;
    endfunction

    // Offer one beat, hold it until taken, then maybe idle
    task automatic send_beat(input sample_t s);
        sample       <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        beats_sent++;
        if (s.cmd == CMD_CLEAR)
            clear_cmds++;
        if (tx_gaps_en && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every decision has come back
    task automatic drain();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_decisions != 0);
    endtask

    task automatic program_gate(input int floor_v, input int ksq_v, input int limit_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VARIANCE_FLOOR;
        cfg_data  <= CFG_DATA_W'(floor_v);
        @(posedge clk);
        cfg_index <= CFG_SIGMA_MULT_SQ;
        cfg_data  <= CFG_DATA_W'(ksq_v);
        @(posedge clk);
        cfg_index <= CFG_BAD_RUN_LIMIT;
        cfg_data  <= CFG_DATA_W'(limit_v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_run++;
    endtask

    // Move the cluster that well-formed samples are drawn from
    task automatic pick_cluster();
        center = int'($urandom_range(0, 16000000)) - 8000000;
        case ($urandom_range(0, 3))
            0: spread = 3;
            1: spread = 100;
            2: spread = 1500;
            default: spread = 40000;
        endcase
    endtask

    // Mostly cluster samples, with outlier runs, clears and full-range noise
    task automatic next_random_beat(output sample_t s);
        int r;
        int offset;
        r = $urandom_range(0, 99);
        if (r < 2)
            s = beat(CMD_CLEAR, int'($urandom));
        else if (r < 6)
        begin
            s.cmd   = CMD_SAMPLE;
            s.angle = ANGLE_W'($urandom);
        end
        else if (outlier_left > 0 || r < 14)
        begin
            if (outlier_left > 0)
                outlier_left--;
            else if (r < 8)
                outlier_left = $urandom_range(1, 6);
            offset = int'($urandom_range(spread * 6 + 2000, spread * 6 + 500000));
            if ($urandom_range(0, 1) == 1)
                offset = -offset;
            s = beat(CMD_SAMPLE, center + offset);
        end
        else
            s = beat(CMD_SAMPLE, center + int'($urandom_range(0, 2 * spread)) - spread);
    endtask

    initial
    begin : stimulus
        int      probes [10];
        int      phase;
        int      item;
        sample_t s;
        probes = '{0, ANGLE_MAX, ANGLE_MIN, 308, 307, ANGLE_MAX, ANGLE_MIN, 5000, -5000, 12};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gaps_en  = 1'b1;
        rx_stall_en <= 1'b1;

        // Directed: clear with a junk angle, fill with zeros so the floor sets the
        // band, then hit the band edge (308 out, 307 in) and overrun the reject limit
        send_beat(beat(CMD_CLEAR, -1));
        repeat (DEFAULT_WINDOW_DEPTH) send_beat(beat(CMD_SAMPLE, 0));
        foreach (probes[i])
            send_beat(beat(CMD_SAMPLE, probes[i]));
        drain();

        // Random phases, one register setting each
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: program_gate(FLOOR_RESET, KSQ_RESET, LIMIT_RESET);
                1: program_gate(0, 0, 0);
                2: program_gate((1 << FLOOR_W) - 1, (1 << KSQ_W) - 1, (1 << LIMIT_W) - 1);
                3: program_gate(0, 64, (1 << LIMIT_W) - 1);
                4: program_gate((1 << FLOOR_W) - 1, 1, 0);
                default: program_gate($urandom_range(0, (1 << FLOOR_W) - 1),
                                      $urandom_range(1, 64),
                                      $urandom_range(0, (1 << LIMIT_W) - 1));
            endcase
            tx_gaps_en  = (phase % 3 != 1) && (phase != PHASES - 1);
            rx_stall_en <= (phase != PHASES - 1);
            pick_cluster();
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                if (item % 40 == 39)
                    pick_cluster();
                // long result-side hold while beats keep coming
                if (phase == 1 && item == 20)
                    rx_hold_req <= rx_hold_req + 1;
                // sender pause until every decision is back
                if (phase == 3 && item == 60)
                    drain();
                next_random_beat(s);
                send_beat(s);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d beats (%0d clear commands) across %0d register settings.",
                 beats_sent, clear_cmds, settings_run);
        $display("Checked %0d decisions: %0d rejections, %0d window wipes.",
                 decisions_checked, samples_rejected, window_wipes);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
